/* rtl/ssdt_pkg.sv */
// Shared types and constants for the scanline span depth test block.
package ssdt_pkg;

    localparam int ROW_W     = 9;
    localparam int COL_W     = 6;
    localparam int PW_W      = 17;
    localparam int NCOLS_W   = 7;
    localparam int NROWS_W   = 10;
    localparam int COLOR_W   = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;

    localparam int RST_LEFT_X  = -16000;
    localparam int RST_PIXEL_W = 512;
    localparam int RST_COLS    = 64;
    localparam int RST_ROWS    = 512;
    localparam int RST_FRONT   = -16384;
    localparam int RST_BACK    = 16384;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_X  = 3'd0,
        REG_PIXEL_W = 3'd1,
        REG_COLS    = 3'd2,
        REG_ROWS    = 3'd3,
        REG_FRONT   = 3'd4,
        REG_BACK    = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_RIGHT,
        S_CLIP,
        S_LC_NUM,
        S_LC,
        S_RC_NUM,
        S_RC,
        S_XP,
        S_DXP,
        S_DZ,
        S_DX,
        S_N0,
        S_STEP,
        S_COL_NUM,
        S_COL_Z,
        S_COL_TEST,
        S_COL_NEXT
    } state_t;

endpackage

/* rtl/scanline_span_depth_test.sv */
// Scanline span depth test: span clip, depth interpolation and z-store update.
// Draw: set-up multiplies and divides for the clipped span, its columns and depth step, then
//   per column one divide on the shared restoring divider; each column waits on out_stall.
// Read: one store read. Clear: one store entry per cycle, SCREEN_WIDTH*SCREEN_HEIGHT entries.
// After reset the store is filled with the back limit in the same pass before the first
//   transaction is taken; one item is in work at a time.
module scanline_span_depth_test
    import ssdt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 512,
    parameter int COORD_BITS    = 18
)(
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    cfg_we,
    input  logic [CFG_IDX_W-1:0]                                    cfg_index,
    input  logic [((COORD_BITS > PW_W) ? COORD_BITS : PW_W)-1:0]    cfg_data,
    input  logic                                                    in_valid,
    output logic                                                    in_stall,
    input  logic [OP_W-1:0]                                         opcode,
    input  logic [ROW_W-1:0]                                        row,
    input  logic [COL_W-1:0]                                        column,
    input  logic signed [COORD_BITS-1:0]                            x_first,
    input  logic signed [COORD_BITS-1:0]                            z_first,
    input  logic signed [COORD_BITS-1:0]                            x_second,
    input  logic signed [COORD_BITS-1:0]                            z_second,
    input  logic [COLOR_W-1:0]                                      red_in,
    input  logic [COLOR_W-1:0]                                      green_in,
    input  logic [COLOR_W-1:0]                                      blue_in,
    output logic                                                    out_valid,
    input  logic                                                    out_stall,
    output logic [ROW_W-1:0]                                        out_row,
    output logic [COL_W-1:0]                                        out_column,
    output logic signed [COORD_BITS-1:0]                            depth,
    output logic [COLOR_W-1:0]                                      red_out,
    output logic [COLOR_W-1:0]                                      green_out,
    output logic [COLOR_W-1:0]                                      blue_out,
    output logic                                                    written,
    output logic                                                    last
);

    localparam int CB     = COORD_BITS;
    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = ((CB > PW_W + COL_W) ? CB : PW_W + COL_W) + 2;
    localparam int MB     = XW + 1;
    localparam int Z_W    = CB + 1;
    localparam int P_W    = MB + Z_W;
    localparam int ALU_W  = P_W + 2;
    localparam int CNT_W  = $clog2(ALU_W + 1);
    localparam logic signed [ALU_W-1:0] Z_MAX = {{(ALU_W-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [ALU_W-1:0] Z_MIN = ~Z_MAX;

    state_t                     state_reg, state_next;
    state_t                     ret_reg, ret_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    logic signed [CB-1:0]       lcx_reg, lcx_next;
    logic [PW_W-1:0]            pw_reg, pw_next;
    logic [NCOLS_W-1:0]         cols_reg, cols_next;
    logic [NROWS_W-1:0]         rows_reg, rows_next;
    logic signed [CB-1:0]       front_reg, front_next;
    logic signed [CB-1:0]       back_reg, back_next;

    logic [ADDR_W-1:0]          clr_ptr_reg, clr_ptr_next;
    logic signed [CB-1:0]       clr_val_reg, clr_val_next;

    logic [ROW_W-1:0]           row_reg, row_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic                       rd_oob_reg, rd_oob_next;
    logic signed [CB-1:0]       x1_reg, x1_next;
    logic signed [CB-1:0]       z1_reg, z1_next;
    logic signed [CB-1:0]       x2_reg, x2_next;
    logic signed [CB-1:0]       z2_reg, z2_next;
    logic [COLOR_W-1:0]         red_reg, red_next;
    logic [COLOR_W-1:0]         green_reg, green_next;
    logic [COLOR_W-1:0]         blue_reg, blue_next;
    logic signed [XW-1:0]       right_reg, right_next;
    logic signed [XW-1:0]       xr_reg, xr_next;
    logic signed [ALU_W-1:0]    tmp_reg, tmp_next;
    logic signed [ALU_W-1:0]    acc_reg, acc_next;
    logic signed [ALU_W-1:0]    mcand_reg, mcand_next;
    logic [MB-1:0]              mplier_reg, mplier_next;
    logic [ALU_W-1:0]           num_reg, num_next;
    logic [ALU_W-1:0]           den_reg, den_next;
    logic [ALU_W-1:0]           rem_reg, rem_next;
    logic [COL_W-1:0]           lc_reg, lc_next;
    logic [COL_W-1:0]           rc_reg, rc_next;
    logic signed [Z_W-1:0]      dz_reg, dz_next;
    logic [CB:0]                dx_reg, dx_next;
    logic signed [ALU_W-1:0]    n_reg, n_next;
    logic signed [ALU_W-1:0]    step_reg, step_next;
    logic signed [CB-1:0]       z_reg, z_next;

    logic                       out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]           out_row_reg, out_row_next;
    logic [COL_W-1:0]           out_col_reg, out_col_next;
    logic signed [CB-1:0]       out_depth_reg, out_depth_next;
    logic [COLOR_W-1:0]         out_red_reg, out_red_next;
    logic [COLOR_W-1:0]         out_green_reg, out_green_next;
    logic [COLOR_W-1:0]         out_blue_reg, out_blue_next;
    logic                       out_written_reg, out_written_next;
    logic                       out_last_reg, out_last_next;

    logic signed [CB-1:0]       depth_mem [DEPTH];
    logic signed [CB-1:0]       rd_data_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic signed [CB-1:0]       mem_wdata;

    logic signed [ALU_W-1:0]    alu_a;
    logic signed [ALU_W-1:0]    alu_b;
    logic                       alu_sub;
    logic signed [ALU_W-1:0]    alu_res;

    logic [NCOLS_W-1:0]         cols_cap;
    logic                       draw_ok;
    logic                       swap;
    logic                       rd_in_range;
    logic [ADDR_W-1:0]          in_addr;
    logic [ADDR_W-1:0]          col_addr;
    logic signed [CB-1:0]       xl_c;
    logic signed [XW-1:0]       xr_c;
    logic                       clip_empty;
    logic                       out_free;
    logic                       last_col;
    logic                       z_wr;
    logic                       n_neg;
    logic [ALU_W-1:0]           rem_shift;
    logic                       cnt_done;

    assign cols_cap    = (int'(cols_reg) < SCREEN_WIDTH) ? cols_reg : NCOLS_W'(SCREEN_WIDTH);
    assign draw_ok     = (cols_cap != '0) && (pw_reg != '0) && (int'(row) < int'(rows_reg))
                         && (int'(row) < SCREEN_HEIGHT) && (x_first != x_second);
    assign swap        = x_first > x_second;
    assign rd_in_range = (int'(row) < SCREEN_HEIGHT) && (int'(column) < SCREEN_WIDTH);
    assign in_addr     = ADDR_W'(int'(row) * SCREEN_WIDTH + int'(column));
    assign col_addr    = ADDR_W'(int'(row_reg) * SCREEN_WIDTH + int'(col_reg));
    assign xl_c        = (x1_reg > lcx_reg) ? x1_reg : lcx_reg;
    assign xr_c        = (XW'(x2_reg) < right_reg) ? XW'(x2_reg) : right_reg;
    assign clip_empty  = XW'(xl_c) > xr_c;
    assign out_free    = !out_valid_reg || !out_stall;
    assign last_col    = col_reg == rc_reg;
    assign z_wr        = (z_reg < rd_data_reg) && (z_reg >= front_reg);
    assign n_neg       = n_reg[ALU_W-1];
    assign rem_shift   = {rem_reg[ALU_W-2:0], num_reg[ALU_W-1]};
    assign cnt_done    = cnt_reg == CNT_W'(1);

    assign in_stall   = state_reg != S_IDLE;
    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_column = out_col_reg;
    assign depth      = out_depth_reg;
    assign red_out    = out_red_reg;
    assign green_out  = out_green_reg;
    assign blue_out   = out_blue_reg;
    assign written    = out_written_reg;
    assign last       = out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_ptr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode_t'(opcode))
                        OP_DRAW:
                        begin
                            if (draw_ok)
                            begin
                                state_next = S_MUL;
                                ret_next   = S_RIGHT;
                            end
                        end
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL, S_DIV:
            begin
                if (cnt_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_RIGHT: state_next = S_CLIP;
            S_CLIP:  state_next = clip_empty ? S_IDLE : S_LC_NUM;
            S_LC_NUM:
            begin
                state_next = S_DIV;
                ret_next   = S_LC;
            end
            S_LC: state_next = S_RC_NUM;
            S_RC_NUM:
            begin
                state_next = S_DIV;
                ret_next   = S_RC;
            end
            S_RC:
            begin
                state_next = S_MUL;
                ret_next   = S_XP;
            end
            S_XP:  state_next = S_DXP;
            S_DXP: state_next = S_DZ;
            S_DZ:  state_next = S_DX;
            S_DX:
            begin
                state_next = S_MUL;
                ret_next   = S_N0;
            end
            S_N0:
            begin
                state_next = S_MUL;
                ret_next   = S_STEP;
            end
            S_STEP: state_next = S_COL_NUM;
            S_COL_NUM:
            begin
                state_next = S_DIV;
                ret_next   = S_COL_Z;
            end
            S_COL_Z: state_next = S_COL_TEST;
            S_COL_TEST:
            begin
                if (out_free)
                begin
                    state_next = last_col ? S_IDLE : S_COL_NEXT;
                end
            end
            S_COL_NEXT: state_next = S_COL_NUM;
            default:    state_next = S_IDLE;
        endcase
    end

    // Shared adder operands
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_MUL:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = cnt_done;
            end
            S_DIV:
            begin
                alu_a   = rem_shift;
                alu_b   = den_reg;
                alu_sub = 1'b1;
            end
            S_RIGHT, S_XP:
            begin
                alu_a = ALU_W'(lcx_reg);
                alu_b = acc_reg;
            end
            S_CLIP:
            begin
                alu_a   = ALU_W'(xl_c);
                alu_b   = ALU_W'(lcx_reg);
                alu_sub = 1'b1;
            end
            S_LC_NUM, S_RC_NUM:
            begin
                alu_a = tmp_reg <<< 1;
                alu_b = ALU_W'(pw_reg);
            end
            S_LC:
            begin
                alu_a   = ALU_W'(xr_reg);
                alu_b   = ALU_W'(lcx_reg);
                alu_sub = 1'b1;
            end
            S_DXP:
            begin
                alu_a   = tmp_reg;
                alu_b   = ALU_W'(x1_reg);
                alu_sub = 1'b1;
            end
            S_DZ:
            begin
                alu_a   = ALU_W'(z2_reg);
                alu_b   = ALU_W'(z1_reg);
                alu_sub = 1'b1;
            end
            S_DX:
            begin
                alu_a   = ALU_W'(x2_reg);
                alu_b   = ALU_W'(x1_reg);
                alu_sub = 1'b1;
            end
            S_COL_NUM:
            begin
                alu_a   = ALU_W'(dx_reg);
                alu_b   = n_reg <<< 1;
                alu_sub = n_neg;
            end
            S_COL_Z:
            begin
                alu_a   = ALU_W'(z1_reg);
                alu_b   = num_reg;
                alu_sub = n_neg;
            end
            S_COL_NEXT:
            begin
                alu_a = n_reg;
                alu_b = step_reg;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // Datapath, store access and result register
    always_comb
    begin
        cnt_next         = cnt_reg;
        lcx_next         = lcx_reg;
        pw_next          = pw_reg;
        cols_next        = cols_reg;
        rows_next        = rows_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        clr_ptr_next     = clr_ptr_reg;
        clr_val_next     = clr_val_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        rd_oob_next      = rd_oob_reg;
        x1_next          = x1_reg;
        z1_next          = z1_reg;
        x2_next          = x2_reg;
        z2_next          = z2_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        right_next       = right_reg;
        xr_next          = xr_reg;
        tmp_next         = tmp_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        lc_next          = lc_reg;
        rc_next          = rc_reg;
        dz_next          = dz_reg;
        dx_next          = dx_reg;
        n_next           = n_reg;
        step_next        = step_reg;
        z_next           = z_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_depth_next   = out_depth_reg;
        out_red_next     = out_red_reg;
        out_green_next   = out_green_reg;
        out_blue_next    = out_blue_reg;
        out_written_next = out_written_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = col_addr;
        mem_raddr        = col_addr;
        mem_wdata        = z_reg;

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT_X:  lcx_next   = cfg_data[CB-1:0];
                REG_PIXEL_W: pw_next    = cfg_data[PW_W-1:0];
                REG_COLS:    cols_next  = cfg_data[NCOLS_W-1:0];
                REG_ROWS:    rows_next  = cfg_data[NROWS_W-1:0];
                REG_FRONT:   front_next = cfg_data[CB-1:0];
                REG_BACK:    back_next  = cfg_data[CB-1:0];
                default:     lcx_next   = lcx_reg;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_ptr_reg;
                mem_wdata = clr_val_reg;
                if (clr_ptr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_ptr_next = '0;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    row_next   = row;
                    col_next   = column;
                    red_next   = red_in;
                    green_next = green_in;
                    blue_next  = blue_in;
                    x1_next    = swap ? x_second : x_first;
                    z1_next    = swap ? z_second : z_first;
                    x2_next    = swap ? x_first : x_second;
                    z2_next    = swap ? z_first : z_second;
                    case (opcode_t'(opcode))
                        OP_DRAW:
                        begin
                            acc_next    = '0;
                            mcand_next  = ALU_W'(pw_reg);
                            mplier_next = MB'(cols_cap - NCOLS_W'(1));
                            cnt_next    = CNT_W'(MB);
                        end
                        OP_CLEAR:
                        begin
                            clr_val_next = back_reg;
                            clr_ptr_next = '0;
                        end
                        OP_READ:
                        begin
                            rd_oob_next = !rd_in_range;
                            mem_re      = rd_in_range;
                            mem_raddr   = in_addr;
                        end
                        default:
                        begin
                            rd_oob_next = rd_oob_reg;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_row_next     = row_reg;
                    out_col_next     = col_reg;
                    out_depth_next   = rd_oob_reg ? back_reg : rd_data_reg;
                    out_red_next     = '0;
                    out_green_next   = '0;
                    out_blue_next    = '0;
                    out_written_next = 1'b0;
                    out_last_next    = 1'b1;
                end
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_res;
                end
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CNT_W'(1);
            end
            S_DIV:
            begin
                if (!alu_res[ALU_W-1])
                begin
                    rem_next = alu_res;
                    num_next = {num_reg[ALU_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    num_next = {num_reg[ALU_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            S_RIGHT:
            begin
                right_next = alu_res[XW-1:0];
            end
            S_CLIP:
            begin
                tmp_next = alu_res;
                xr_next  = xr_c;
            end
            S_LC_NUM, S_RC_NUM:
            begin
                num_next = alu_res;
                den_next = ALU_W'({pw_reg, 1'b0});
                rem_next = '0;
                cnt_next = CNT_W'(ALU_W);
            end
            S_LC:
            begin
                lc_next  = num_reg[COL_W-1:0];
                tmp_next = alu_res;
            end
            S_RC:
            begin
                rc_next     = num_reg[COL_W-1:0];
                acc_next    = '0;
                mcand_next  = ALU_W'(pw_reg);
                mplier_next = MB'(lc_reg);
                cnt_next    = CNT_W'(MB);
            end
            S_XP, S_DXP:
            begin
                tmp_next = alu_res;
            end
            S_DZ:
            begin
                dz_next = alu_res[Z_W-1:0];
            end
            S_DX:
            begin
                dx_next     = alu_res[CB:0];
                acc_next    = '0;
                mcand_next  = ALU_W'(dz_reg);
                mplier_next = tmp_reg[MB-1:0];
                cnt_next    = CNT_W'(MB);
            end
            S_N0:
            begin
                n_next      = acc_reg;
                acc_next    = '0;
                mcand_next  = ALU_W'(dz_reg);
                mplier_next = MB'(pw_reg);
                cnt_next    = CNT_W'(MB);
            end
            S_STEP:
            begin
                step_next = acc_reg;
                col_next  = lc_reg;
            end
            S_COL_NUM:
            begin
                num_next = alu_res;
                den_next = ALU_W'({dx_reg, 1'b0});
                rem_next = '0;
                cnt_next = CNT_W'(ALU_W);
                mem_re   = 1'b1;
            end
            S_COL_Z:
            begin
                if (alu_res > Z_MAX)
                begin
                    z_next = Z_MAX[CB-1:0];
                end
                else if (alu_res < Z_MIN)
                begin
                    z_next = Z_MIN[CB-1:0];
                end
                else
                begin
                    z_next = alu_res[CB-1:0];
                end
            end
            S_COL_TEST:
            begin
                if (out_free)
                begin
                    mem_we           = z_wr;
                    out_valid_next   = 1'b1;
                    out_row_next     = row_reg;
                    out_col_next     = col_reg;
                    out_depth_next   = z_reg;
                    out_red_next     = z_wr ? red_reg : '0;
                    out_green_next   = z_wr ? green_reg : '0;
                    out_blue_next    = z_wr ? blue_reg : '0;
                    out_written_next = z_wr;
                    out_last_next    = last_col;
                end
            end
            S_COL_NEXT:
            begin
                n_next   = alu_res;
                col_next = col_reg + COL_W'(1);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= depth_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            cnt_reg       <= '0;
            lcx_reg       <= CB'(RST_LEFT_X);
            pw_reg        <= PW_W'(RST_PIXEL_W);
            cols_reg      <= NCOLS_W'(RST_COLS);
            rows_reg      <= NROWS_W'(RST_ROWS);
            front_reg     <= CB'(RST_FRONT);
            back_reg      <= CB'(RST_BACK);
            clr_ptr_reg   <= '0;
            clr_val_reg   <= CB'(RST_BACK);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            lcx_reg       <= lcx_next;
            pw_reg        <= pw_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            clr_ptr_reg   <= clr_ptr_next;
            clr_val_reg   <= clr_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        col_reg         <= col_next;
        rd_oob_reg      <= rd_oob_next;
        x1_reg          <= x1_next;
        z1_reg          <= z1_next;
        x2_reg          <= x2_next;
        z2_reg          <= z2_next;
        red_reg         <= red_next;
        green_reg       <= green_next;
        blue_reg        <= blue_next;
        right_reg       <= right_next;
        xr_reg          <= xr_next;
        tmp_reg         <= tmp_next;
        acc_reg         <= acc_next;
        mcand_reg       <= mcand_next;
        mplier_reg      <= mplier_next;
        num_reg         <= num_next;
        den_reg         <= den_next;
        rem_reg         <= rem_next;
        lc_reg          <= lc_next;
        rc_reg          <= rc_next;
        dz_reg          <= dz_next;
        dx_reg          <= dx_next;
        n_reg           <= n_next;
        step_reg        <= step_next;
        z_reg           <= z_next;
        out_row_reg     <= out_row_next;
        out_col_reg     <= out_col_next;
        out_depth_reg   <= out_depth_next;
        out_red_reg     <= out_red_next;
        out_green_reg   <= out_green_next;
        out_blue_reg    <= out_blue_next;
        out_written_reg <= out_written_next;
        out_last_reg    <= out_last_next;
    end

endmodule
